@@ design/tlne_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlne_pkg: shared types and constants
// Character codes, register indexes and the job descriptor that carries one
// classified input byte from the front end to the back end.
// ----------------------------------------------------------------------------
package tlne_pkg;

  localparam int MAX_DIGITS = 12;
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int WCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int ESC_MAX    = 4;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CTRL_FLIP = 8'h40;
  localparam logic [7:0] CTRL_TOP  = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ALL      = 3'd0,
    REG_NUM_NONBLANK = 3'd1,
    REG_SQUEEZE      = 3'd2,
    REG_SHOW_ENDS    = 3'd3,
    REG_SHOW_TABS    = 3'd4,
    REG_SHOW_NONPR   = 3'd5,
    REG_NUM_WIDTH    = 3'd6
  } cfg_reg_t;

  typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic                  do_num;   // emit a line number prefix first
    bcd_t                  bcd;      // counter value to show
    logic [IDX_W-1:0]      wtop;     // field width minus one
    logic [IDX_W-1:0]      top;      // highest nonzero digit in the field
    logic [ESC_MAX-1:0][7:0] esc;    // escaped data byte, first at [0]
    logic [1:0]            esc_last; // index of the final escape byte
  } job_t;

endpackage

@@ design/tlne_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlne_front: input classification
// Holds configuration and line state, squeezes blank lines, snapshots and
// advances the BCD line counter and builds the escaped form of each byte.
// ----------------------------------------------------------------------------
module tlne_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [tlne_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlne_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_fire,
  input  logic [7:0]                     data_byte,
  input  logic                           end_of_file,
  output logic                           push,
  output tlne_pkg::job_t                 push_job
);
  import tlne_pkg::*;

  logic       number_all_lines;
  logic       number_nonblank_lines;
  logic       squeeze_blank;
  logic       show_ends;
  logic       show_tabs;
  logic       show_nonprinting;
  logic [3:0] number_width;

  logic at_line_start;
  logic blank_seen;
  bcd_t line_count;
  bcd_t line_count_next;

  logic              is_nl;
  logic              empty_line;
  logic              drop;
  logic              do_num;
  logic [WCNT_W-1:0] w_eff;
  logic [IDX_W-1:0]  wtop;
  logic [IDX_W-1:0]  top;
  logic              carry;
  logic [7:0]        c7;
  logic [7:0]        c_fin;
  logic              ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_all_lines      <= 1'b0;
      number_nonblank_lines <= 1'b0;
      squeeze_blank         <= 1'b0;
      show_ends             <= 1'b0;
      show_tabs             <= 1'b0;
      show_nonprinting      <= 1'b0;
      number_width          <= 4'd6;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_ALL:      number_all_lines      <= cfg_data[0];
        REG_NUM_NONBLANK: number_nonblank_lines <= cfg_data[0];
        REG_SQUEEZE:      squeeze_blank         <= cfg_data[0];
        REG_SHOW_ENDS:    show_ends             <= cfg_data[0];
        REG_SHOW_TABS:    show_tabs             <= cfg_data[0];
        REG_SHOW_NONPR:   show_nonprinting      <= cfg_data[0];
        REG_NUM_WIDTH:    number_width          <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    is_nl      = (data_byte == CH_NL);
    empty_line = is_nl && at_line_start;
    drop       = empty_line && squeeze_blank && blank_seen;
    do_num     = at_line_start &&
                 (number_nonblank_lines ? !empty_line : number_all_lines);

    if (number_width == 4'd0) begin
      w_eff = WCNT_W'(1);
    end else if (int'(number_width) > MAX_DIGITS) begin
      w_eff = WCNT_W'(MAX_DIGITS);
    end else begin
      w_eff = WCNT_W'(number_width);
    end
    wtop = IDX_W'(w_eff - 1'b1);

    // increment within the field; digits above it are cleared
    carry = 1'b1;
    top   = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (IDX_W'(i) <= wtop) begin
        if (line_count[i] != 4'd0) top = IDX_W'(i);
        if (carry) begin
          line_count_next[i] = (line_count[i] == 4'd9) ? 4'd0 : line_count[i] + 4'd1;
        end else begin
          line_count_next[i] = line_count[i];
        end
        carry = carry && (line_count[i] == 4'd9);
      end else begin
        line_count_next[i] = 4'd0;
      end
    end
  end

  // escape encoding of the data byte
  always_comb begin
    c7    = {1'b0, data_byte[6:0]};
    ctl   = (c7 < CTRL_TOP) || (c7 == CH_DEL);
    c_fin = ctl ? (c7 ^ CTRL_FLIP) : c7;

    push_job.do_num   = do_num;
    push_job.bcd      = line_count;
    push_job.wtop     = wtop;
    push_job.top      = top;
    push_job.esc      = '0;
    push_job.esc[0]   = data_byte;
    push_job.esc_last = 2'd0;
    if (is_nl) begin
      if (show_ends) begin
        push_job.esc[0]   = CH_DOLLAR;
        push_job.esc[1]   = CH_NL;
        push_job.esc_last = 2'd1;
      end
    end else if (data_byte == CH_TAB) begin
      if (show_tabs) begin
        push_job.esc[0]   = CH_CARET;
        push_job.esc[1]   = CH_I;
        push_job.esc_last = 2'd1;
      end
    end else if (show_nonprinting) begin
      case ({data_byte[7], ctl})
        2'b11: begin
          push_job.esc[0]   = CH_M;
          push_job.esc[1]   = CH_DASH;
          push_job.esc[2]   = CH_CARET;
          push_job.esc[3]   = c_fin;
          push_job.esc_last = 2'd3;
        end
        2'b10: begin
          push_job.esc[0]   = CH_M;
          push_job.esc[1]   = CH_DASH;
          push_job.esc[2]   = c_fin;
          push_job.esc_last = 2'd2;
        end
        2'b01: begin
          push_job.esc[0]   = CH_CARET;
          push_job.esc[1]   = c_fin;
          push_job.esc_last = 2'd1;
        end
        default: push_job.esc[0] = c_fin;
      endcase
    end
  end

  assign push = in_fire && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      blank_seen    <= 1'b0;
      line_count    <= bcd_t'(1);
    end else if (in_fire) begin
      if (drop) begin
        at_line_start <= 1'b1;
      end else begin
        if (do_num) line_count <= line_count_next;
        blank_seen    <= empty_line;
        at_line_start <= is_nl || end_of_file;
      end
    end
  end

endmodule

@@ design/tlne_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlne_queue: job queue
// Small first-in first-out buffer of job descriptors between the two ends.
// ----------------------------------------------------------------------------
module tlne_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tlne_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output tlne_pkg::job_t head,
  output logic           empty
);
  import tlne_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ design/tlne_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlne_back: output sequencer
// Walks one job a byte per cycle while out_ready allows: number digits, two
// spaces, escape bytes, into a registered output stage.
// ----------------------------------------------------------------------------
module tlne_back (
  input  logic           clk,
  input  logic           rst,
  input  tlne_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_of_run
);
  import tlne_pkg::*;

  typedef enum logic [3:0] {
    PH_DIGIT  = 4'b0001,
    PH_SPACE1 = 4'b0010,
    PH_SPACE2 = 4'b0100,
    PH_ESC    = 4'b1000
  } phase_t;

  phase_t           phase;
  phase_t           phase_next;
  phase_t           cur_phase;
  logic             mid;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] cur_idx;
  logic             load;
  logic [7:0]       byte_val;
  logic             is_last;
  logic [3:0]       dig;
  logic [3:0]       dig_mod;

  assign load = !empty && (!out_valid || out_ready);

  always_comb begin
    if (mid) begin
      cur_phase = phase;
      cur_idx   = idx;
    end else if (head.do_num) begin
      cur_phase = PH_DIGIT;
      cur_idx   = head.wtop;
    end else begin
      cur_phase = PH_ESC;
      cur_idx   = '0;
    end

    dig      = head.bcd[cur_idx];
    dig_mod  = (dig > 4'd9) ? dig - 4'd10 : dig;
    byte_val = CH_SPACE;
    is_last  = 1'b0;
    phase_next = cur_phase;
    idx_next   = cur_idx;

    unique case (cur_phase)
      PH_DIGIT: begin
        if (cur_idx <= head.top) byte_val = CH_ZERO + {4'd0, dig_mod};
        if (cur_idx == '0) phase_next = PH_SPACE1;
        else idx_next = cur_idx - 1'b1;
      end
      PH_SPACE1: phase_next = PH_SPACE2;
      PH_SPACE2: begin
        phase_next = PH_ESC;
        idx_next   = '0;
      end
      PH_ESC: begin
        byte_val = head.esc[cur_idx[1:0]];
        is_last  = (cur_idx[1:0] == head.esc_last);
        idx_next = cur_idx + 1'b1;
      end
      default: ;
    endcase
  end

  assign pop = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid       <= 1'b0;
      phase     <= PH_ESC;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        mid       <= !is_last;
        phase     <= phase_next;
        idx       <= idx_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= byte_val;
      last_of_run <= is_last;
    end
  end

endmodule

@@ design/text_line_number_and_escape.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_number_and_escape: line numbering and escape filter
// Squeezes blank lines, prefixes line numbers and shows ends, tabs and
// non-printing bytes in caret and M- notation.
// ----------------------------------------------------------------------------
// Each input byte becomes 0 to 18 output bytes, one output transfer per
// cycle while out_ready allows: the data byte itself gives 1 to 4 (newline
// with '$', "^I", "M-^X"), and a numbered line start adds number_width
// digits (clamped to 1 to 12) plus two spaces. A squeezed blank line gives
// no output and queues no job. The input side takes a transfer in every
// cycle while the four-entry job queue has room, so the sustained input
// rate is set by the output sequencer. The front end classifies each byte,
// advances the BCD line counter and queues a job; the back end spells out
// the job byte by byte into a registered output, so both sides stall
// independently. last_of_run marks the final output byte of each input.
// Configuration writes are taken in any cycle (cfg_ready is always high);
// an index beyond the register list is ignored. Write them only while idle.
// ----------------------------------------------------------------------------
module text_line_number_and_escape (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlne_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlne_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      data_byte,
  input  logic                            end_of_file,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            last_of_run
);
  import tlne_pkg::*;

  logic in_fire;
  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t push_job;
  job_t head;

  assign cfg_ready = 1'b1;
  // a squeezed byte pushes nothing, but the gate stays simple
  assign in_ready  = !full;
  assign in_fire   = in_valid && in_ready;

  tlne_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_fire     (in_fire),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .push        (push),
    .push_job    (push_job)
  );

  tlne_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  tlne_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
